// ===== hw/rtl/acmac_pkg.sv =====
// Shared types, constants and AES helper functions for the CMAC engine.
`default_nettype none
package acmac_pkg;
  localparam int BLOCK_BYTES = 16;
  localparam logic [7:0] RB_CONST = 8'h87;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUBKEY,
    ST_LOAD,
    ST_CHAIN,
    ST_FINAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [127:0] block;
    logic [127:0] key;
  } aes_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [127:0] result;
  } aes_rsp_t;

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  // Byte i of a 128-bit word, byte 0 in the top bits.
  function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
    byte_at = w[127 - 8*i -: 8];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/acmac_aes_core.sv =====
// Byte-serial AES-128 encipher core: one state S-box and one key S-box, used in turn, one byte per cycle.
`default_nettype none
module acmac_aes_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire acmac_pkg::aes_req_t req,
  output acmac_pkg::aes_rsp_t rsp
);
  import acmac_pkg::*;

  // Per round: SubBytes (state rotates a byte each cycle), then the key S-box on the last
  // round-key word byte by byte, then ShiftRows/MixColumns/AddRoundKey (no MixColumns in round 10).
  logic [127:0] st;
  logic [127:0] rk;
  logic [7:0] rcon;
  logic [3:0] round;
  logic [4:0] step;
  logic busy;
  logic done;
  logic [31:0] kword;

  logic [127:0] sr;
  logic [127:0] mixed;
  logic [127:0] rk_next;

  always_comb begin
    logic [7:0] a0, a1, a2, a3, x;
    sr = '0;
    mixed = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[127 - 8*(c*4+i) -: 8] = byte_at(st, ((c + i) % 4) * 4 + i);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(sr, c*4);
      a1 = byte_at(sr, c*4+1);
      a2 = byte_at(sr, c*4+2);
      a3 = byte_at(sr, c*4+3);
      x = a0 ^ a1 ^ a2 ^ a3;
      mixed[127 - 8*(c*4) -: 8] = a0 ^ x ^ xt(a0 ^ a1);
      mixed[127 - 8*(c*4+1) -: 8] = a1 ^ x ^ xt(a1 ^ a2);
      mixed[127 - 8*(c*4+2) -: 8] = a2 ^ x ^ xt(a2 ^ a3);
      mixed[127 - 8*(c*4+3) -: 8] = a3 ^ x ^ xt(a3 ^ a0);
    end
    rk_next[127:96] = rk[127:96] ^ kword;
    rk_next[95:64] = rk[95:64] ^ rk_next[127:96];
    rk_next[63:32] = rk[63:32] ^ rk_next[95:64];
    rk_next[31:0] = rk[31:0] ^ rk_next[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        st <= req.block ^ req.key;
        rk <= req.key;
        rcon <= 8'h01;
        round <= 4'd1;
        step <= '0;
      end else if (busy) begin
        if (step < 5'd16) begin
          st <= {st[119:0], sbox(st[127:120])};
          step <= step + 5'd1;
        end else if (step < 5'd20) begin
          // key schedule: rotated S-box of last word, one byte per cycle
          kword <= {kword[23:0],
                    sbox(rk[8*(((4'(step - 5'd16) + 4'd1) & 4'd3) ^ 4'd3) +: 8])
                    ^ ((step == 5'd16) ? rcon : 8'h00)};
          step <= step + 5'd1;
        end else begin
          st <= ((round == 4'd10) ? sr : mixed) ^ rk_next;
          rk <= rk_next;
          rcon <= xt(rcon);
          step <= '0;
          if (round == 4'd10) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          round <= round + 4'd1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.result = st;
endmodule
`default_nettype wire

// ===== hw/rtl/aes_cmac_tag_engine.sv =====
// AES-CMAC-128 tag engine: top level with byte buffer, subkeys and control.
// Flow: a byte not after a full block frees the input after the accept and load states;
//   a byte after a full block and the first item of a message each wait one AES pass (its
//   length is set by the byte-serial S-box path of the AES core).
// A final item ends with one more AES pass (a data byte first takes the load state once more),
//   then the tag waits in an output register.
// Reset (rst, synchronous, active high) clears keys, subkey-ready flag, chaining value
//   and control.
`default_nettype none
module aes_cmac_tag_engine (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] msg_byte
  input  wire logic s_tuser,         // [0] has_data
  input  wire logic s_tlast,         // is_last
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [127:0] m_tdata       // [63:0] mac_high, [127:64] mac_low
);
  import acmac_pkg::*;

  logic [63:0] key_high, key_low;
  logic [127:0] k1, k2;
  logic subkeys_ready;
  logic [127:0] chain;
  logic [127:0] buffer;        // bytes shift in at the bottom
  logic [4:0] fill_count;
  logic [7:0] held_byte;
  logic held_data, held_last;
  state_t state, state_next;
  aes_req_t req;
  aes_rsp_t rsp;
  logic [127:0] final_block;
  logic [127:0] padded;
  logic [127:0] l_dbl, l_dbl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_HIGH) key_high <= cfg_data;
      else key_low <= cfg_data;
    end
  end

  acmac_aes_core u_core (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // Pad: held bytes sit in the low bytes; move them up, 0x80 after, zeros below.
  always_comb begin
    padded = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < fill_count)
        padded[127 - 8*i -: 8] = buffer[8*(32'(fill_count) - 1 - i) +: 8];
      else if (5'(i) == fill_count)
        padded[127 - 8*i -: 8] = PAD_BYTE;
    end
    final_block = padded ^ ((fill_count == 5'(BLOCK_BYTES)) ? k1 : k2);
    l_dbl = {rsp.result[126:0], 1'b0} ^ (rsp.result[127] ? 128'(RB_CONST) : '0);
    l_dbl2 = {l_dbl[126:0], 1'b0} ^ (l_dbl[127] ? 128'(RB_CONST) : '0);
  end

  always_comb begin
    state_next = state;
    req.start = 1'b0;
    req.key = {key_high, key_low};
    req.block = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = subkeys_ready ? ST_LOAD : ST_SUBKEY;
      end
      ST_SUBKEY: if (rsp.done) state_next = ST_LOAD;
                 else req.start = !rsp.busy;
      ST_LOAD: begin
        if (held_data && fill_count == 5'(BLOCK_BYTES)) begin
          req.start = 1'b1;
          req.block = chain ^ buffer;
          state_next = ST_CHAIN;
        end else if (held_data) begin
          // byte goes into the buffer this cycle; a final request pads next cycle
          state_next = held_last ? ST_LOAD : ST_IDLE;
        end else if (held_last) begin
          req.start = 1'b1;
          req.block = chain ^ final_block;
          state_next = ST_FINAL;
        end else state_next = ST_IDLE;
      end
      ST_CHAIN: if (rsp.done) state_next = ST_LOAD;
      ST_FINAL: if (rsp.done) state_next = ST_OUT;
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      subkeys_ready <= 1'b0;
      fill_count <= '0;
      chain <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (s_tvalid) begin
          held_byte <= s_tdata;
          held_data <= s_tuser;
          held_last <= s_tlast;
        end
        ST_SUBKEY: if (rsp.done) begin
          k1 <= l_dbl;
          k2 <= l_dbl2;
          subkeys_ready <= 1'b1;
        end
        ST_LOAD: begin
          if (held_data && fill_count != 5'(BLOCK_BYTES)) begin
            buffer <= {buffer[119:0], held_byte};
            fill_count <= fill_count + 5'd1;
            held_data <= 1'b0;
          end
        end
        ST_CHAIN: if (rsp.done) begin
          chain <= rsp.result;
          fill_count <= '0;
        end
        ST_FINAL: if (rsp.done) begin
          m_tdata <= {rsp.result[63:0], rsp.result[127:64]};
          m_tvalid <= 1'b1;
          chain <= '0;
          fill_count <= '0;
          subkeys_ready <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // fill never passes a full block
  a_fill: assert property (@(posedge clk) disable iff (rst) fill_count <= 5'(BLOCK_BYTES))
    else $error("fill overflow");
  // a tag appears only after the final AES pass
  a_tag: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINAL) else $error("stray tag");
  // no input taken while a tag waits
  a_hold: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("accept during output");
`endif
endmodule
`default_nettype wire
